FILE: hdl/assert_macros.svh
// Assertion macros used by the checking file tqe_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check, clocked, disabled in reset.
`define TQE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: port check failed");

// Value holds in the cycle after cond.
`define TQE_HOLD(lbl, clk, rst, cond, val) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(val)) \
      else $error("%m: hold check failed");

`endif

FILE: hdl/tqe_pkg.sv
// Package: types and constants of the timer queue engine.
package tqe_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int RESULT_CAP     = 16;
   localparam int RES_IDX_W      = $clog2(RESULT_CAP);
   localparam int RES_CNT_W      = $clog2(RESULT_CAP + 1);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2,
      OP_DONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY,
      S_SELECT,
      S_SUMMARY,
      S_EMIT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] interval_ms;
      logic [31:0] target_id;
      logic        repeat_req;
   } item_type;

endpackage

FILE: hdl/timer_queue_engine_top.sv
// Timer queue engine: a table of NUM_TIMERS software timers and a ms counter. Items queue
// in a two-deep front buffer. The timer table has one read port, so every lookup is a
// scan of all NUM_TIMERS slots. An add runs the summary scan only; remove and done run a
// search scan and then the summary scan; a tick that finds nothing due runs one empty
// selection scan and the summary scan; a tick that reports k due timers (k below 16) runs
// one selection scan per reported timer, a final empty scan and the summary scan for
// time_left. A tick that reports 16 skips the empty scan. Results leave one per cycle
// through an output register while the result side does not stall.
module timer_queue_engine_top #(
   parameter int NUM_TIMERS = tqe_pkg::NUM_TIMERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_interval_ms,
   input  logic [31:0] req_timer_id,
   input  logic        req_repeat_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic        rsp_expired,
   output logic        rsp_any_armed,
   output logic [31:0] rsp_time_left,
   output logic        rsp_last
);

   logic              q_valid;
   logic              q_pop;
   tqe_pkg::item_type q_item;

   tqe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_interval_ms (req_interval_ms),
      .req_timer_id    (req_timer_id),
      .req_repeat_req  (req_repeat_req),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   tqe_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_result_id (rsp_result_id),
      .rsp_expired   (rsp_expired),
      .rsp_any_armed (rsp_any_armed),
      .rsp_time_left (rsp_time_left),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: hdl/tqe_front.sv
// Front end: accepts items, decodes the opcode and queues them for the engine.
module tqe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [31:0]       req_interval_ms,
   input  logic [31:0]       req_timer_id,
   input  logic              req_repeat_req,
   output logic              q_valid,
   output tqe_pkg::item_type q_item,
   input  logic              q_pop
);

   tqe_pkg::item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   tqe_pkg::item_type new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.op          = tqe_pkg::op_type'(req_opcode);
      new_item.interval_ms = req_interval_ms;
      new_item.target_id   = req_timer_id;
      new_item.repeat_req  = req_repeat_req;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hdl/tqe_engine.sv
// Back end: timer table, scan sequencer, result buffer and output register.
module tqe_engine #(
   parameter int NUM_TIMERS = tqe_pkg::NUM_TIMERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tqe_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_result_id,
   output logic              rsp_expired,
   output logic              rsp_any_armed,
   output logic [31:0]       rsp_time_left,
   output logic              rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int RCW   = tqe_pkg::RES_CNT_W;
   localparam int RIW   = tqe_pkg::RES_IDX_W;

   tqe_pkg::state_type state_ff, state_in;
   tqe_pkg::op_type    op_ff, op_in;
   logic [31:0] tid_ff, tid_in;
   logic        rep_ff, rep_in;
   logic [NUM_TIMERS-1:0] used_ff, used_in, armed_ff, armed_in;
   logic [47:0] now_ff, now_in;
   logic [31:0] idc_ff, idc_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic        rdv_ff, rdv_in;
   logic [IDX_W-1:0] rd_slot_ff, rd_idx;
   logic [31:0] rd_id_ff, rd_per_ff;
   logic [47:0] rd_dl_ff;
   logic        found_ff, found_in;
   logic [IDX_W-1:0] fslot_ff, fslot_in;
   logic [47:0] fdl_ff, fdl_in;
   logic [31:0] fid_ff, fid_in, fper_ff, fper_in;
   logic [RCW-1:0] res_cnt_ff, res_cnt_in, emit_cnt_ff, emit_cnt_in, emit_next;
   tqe_pkg::status_type res_sts_ff, res_sts_in;
   logic        res_exp_ff, res_exp_in;
   logic        any_ff, any_in;
   logic [31:0] left_ff, left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_id_ff, rsp_id_in, rsp_left_ff, rsp_left_in;
   logic        rsp_exp_ff, rsp_exp_in, rsp_any_ff, rsp_any_in, rsp_last_ff, rsp_last_in;

   // timer table, one write and one registered read port
   logic [31:0] ident_mem [NUM_TIMERS];
   logic [47:0] dl_mem    [NUM_TIMERS];
   logic [31:0] per_mem   [NUM_TIMERS];
   logic        id_we, dl_we;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0] wr_id, wr_per;
   logic [47:0] wr_dl;

   logic [31:0] res_buf_ff [tqe_pkg::RESULT_CAP];
   logic        buf_we;
   logic [RIW-1:0] buf_idx;
   logic [31:0] buf_data;

   logic        scanning, issue, scan_done, out_free, sel_stop;
   logic        free_any;
   logic [IDX_W-1:0] free_idx;
   logic        rd_used, rd_armed, srch_match, sel_better, sum_better;
   logic [47:0] diff;

   assign scanning  = (state_ff == tqe_pkg::S_SEARCH) || (state_ff == tqe_pkg::S_SELECT) ||
                      (state_ff == tqe_pkg::S_SUMMARY);
   assign issue     = scanning && (scan_cnt_ff != CNT_W'(NUM_TIMERS));
   assign rd_idx    = scan_cnt_ff[IDX_W-1:0];
   assign scan_done = (scan_cnt_ff == CNT_W'(NUM_TIMERS)) && !rdv_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sel_stop  = found_ff && (res_cnt_ff == RCW'(tqe_pkg::RESULT_CAP - 1));
   assign emit_next = emit_cnt_ff + RCW'(1);
   assign rd_used   = used_ff[rd_slot_ff];
   assign rd_armed  = armed_ff[rd_slot_ff];
   assign diff      = fdl_ff - now_ff;

   assign srch_match = rd_used && (rd_id_ff == tid_ff) &&
                       ((op_ff != tqe_pkg::OP_DONE) || !rd_armed);
   assign sel_better = rd_used && rd_armed && (rd_dl_ff <= now_ff) &&
                       (!found_ff || (rd_dl_ff < fdl_ff) ||
                        ((rd_dl_ff == fdl_ff) && (rd_id_ff < fid_ff)));
   assign sum_better = rd_used && rd_armed && (!found_ff || (rd_dl_ff < fdl_ff));

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tqe_pkg::S_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  tqe_pkg::OP_ADD:                    state_in = tqe_pkg::S_SUMMARY;
                  tqe_pkg::OP_REMOVE, tqe_pkg::OP_DONE: state_in = tqe_pkg::S_SEARCH;
                  tqe_pkg::OP_TICK:                   state_in = tqe_pkg::S_SELECT;
                  default:                            state_in = tqe_pkg::S_IDLE;
               endcase
            end
         end
         tqe_pkg::S_SEARCH: if (scan_done) state_in = tqe_pkg::S_APPLY;
         tqe_pkg::S_APPLY:  state_in = tqe_pkg::S_SUMMARY;
         tqe_pkg::S_SELECT: begin
            if (scan_done && (!found_ff || sel_stop)) state_in = tqe_pkg::S_SUMMARY;
         end
         tqe_pkg::S_SUMMARY: if (scan_done) state_in = tqe_pkg::S_EMIT;
         tqe_pkg::S_EMIT: begin
            if (out_free && (emit_next == res_cnt_ff)) state_in = tqe_pkg::S_IDLE;
         end
         default: state_in = tqe_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop       = 1'b0;
      op_in       = op_ff;
      tid_in      = tid_ff;
      rep_in      = rep_ff;
      used_in     = used_ff;
      armed_in    = armed_ff;
      now_in      = now_ff;
      idc_in      = idc_ff;
      scan_cnt_in = issue ? scan_cnt_ff + CNT_W'(1) : scan_cnt_ff;
      rdv_in      = issue;
      found_in    = found_ff;
      fslot_in    = fslot_ff;
      fdl_in      = fdl_ff;
      fid_in      = fid_ff;
      fper_in     = fper_ff;
      res_cnt_in  = res_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      res_sts_in  = res_sts_ff;
      res_exp_in  = res_exp_ff;
      any_in      = any_ff;
      left_in     = left_ff;
      id_we       = 1'b0;
      dl_we       = 1'b0;
      wr_idx      = free_idx;
      wr_id       = idc_ff + 32'd1;
      wr_per      = q_item.interval_ms;
      wr_dl       = now_ff + {16'd0, q_item.interval_ms};
      buf_we      = 1'b0;
      buf_idx     = '0;
      buf_data    = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_any_in    = rsp_any_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         tqe_pkg::S_IDLE: begin
            scan_cnt_in = '0;
            found_in    = 1'b0;
            res_exp_in  = 1'b0;
            res_sts_in  = tqe_pkg::STS_OK;
            res_cnt_in  = '0;
            if (q_valid) begin
               q_pop  = 1'b1;
               op_in  = q_item.op;
               tid_in = q_item.target_id;
               rep_in = q_item.repeat_req;
               if (q_item.op == tqe_pkg::OP_ADD) begin
                  res_cnt_in = RCW'(1);
                  buf_we     = 1'b1;
                  if (free_any) begin
                     id_we              = 1'b1;
                     dl_we              = 1'b1;
                     used_in[free_idx]  = 1'b1;
                     armed_in[free_idx] = 1'b1;
                     idc_in             = idc_ff + 32'd1;
                     buf_data           = idc_ff + 32'd1;
                  end else begin
                     res_sts_in = tqe_pkg::STS_FULL;
                  end
               end else if (q_item.op == tqe_pkg::OP_TICK) begin
                  now_in = now_ff + 48'd1;
               end
            end
         end
         tqe_pkg::S_SEARCH: begin
            if (rdv_ff && srch_match && !found_ff) begin
               found_in = 1'b1;
               fslot_in = rd_slot_ff;
               fper_in  = rd_per_ff;
            end
         end
         tqe_pkg::S_APPLY: begin
            res_cnt_in  = RCW'(1);
            buf_we      = 1'b1;
            scan_cnt_in = '0;
            found_in    = 1'b0;
            if (!found_ff) begin
               res_sts_in = tqe_pkg::STS_NOT_FOUND;
            end else if (op_ff == tqe_pkg::OP_REMOVE) begin
               used_in[fslot_ff]  = 1'b0;
               armed_in[fslot_ff] = 1'b0;
            end else if (rep_ff) begin
               armed_in[fslot_ff] = 1'b1;
               dl_we  = 1'b1;
               wr_idx = fslot_ff;
               wr_dl  = now_ff + {16'd0, fper_ff};
            end else begin
               used_in[fslot_ff] = 1'b0;
            end
         end
         tqe_pkg::S_SELECT: begin
            if (rdv_ff && sel_better) begin
               found_in = 1'b1;
               fslot_in = rd_slot_ff;
               fdl_in   = rd_dl_ff;
               fid_in   = rd_id_ff;
            end
            if (scan_done) begin
               scan_cnt_in = '0;
               found_in    = 1'b0;
               buf_we      = 1'b1;
               buf_idx     = res_cnt_ff[RIW-1:0];
               if (found_ff) begin
                  armed_in[fslot_ff] = 1'b0;
                  buf_data   = fid_ff;
                  res_cnt_in = res_cnt_ff + RCW'(1);
                  res_exp_in = 1'b1;
               end else if (res_cnt_ff == '0) begin
                  res_cnt_in = RCW'(1);
               end else begin
                  buf_we = 1'b0;
               end
            end
         end
         tqe_pkg::S_SUMMARY: begin
            if (rdv_ff && sum_better) begin
               found_in = 1'b1;
               fdl_in   = rd_dl_ff;
            end
            if (scan_done) begin
               emit_cnt_in = '0;
               any_in      = found_ff;
               if (found_ff && (fdl_ff > now_ff)) begin
                  left_in = (diff[47:32] != 16'd0) ? 32'hFFFF_FFFF : diff[31:0];
               end else begin
                  left_in = '0;
               end
            end
         end
         tqe_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_sts_ff;
               rsp_id_in     = res_buf_ff[emit_cnt_ff[RIW-1:0]];
               rsp_exp_in    = res_exp_ff;
               rsp_any_in    = any_ff;
               rsp_left_in   = left_ff;
               rsp_last_in   = (emit_next == res_cnt_ff);
               emit_cnt_in   = emit_next;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqe_pkg::S_IDLE;
         used_ff      <= '0;
         armed_ff     <= '0;
         now_ff       <= '0;
         idc_ff       <= '0;
         scan_cnt_ff  <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         res_cnt_ff   <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         armed_ff     <= armed_in;
         now_ff       <= now_in;
         idc_ff       <= idc_in;
         scan_cnt_ff  <= scan_cnt_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         res_cnt_ff   <= res_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      rep_ff        <= rep_in;
      fslot_ff      <= fslot_in;
      fdl_ff        <= fdl_in;
      fid_ff        <= fid_in;
      fper_ff       <= fper_in;
      res_sts_ff    <= res_sts_in;
      res_exp_ff    <= res_exp_in;
      any_ff        <= any_in;
      left_ff       <= left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_any_ff    <= rsp_any_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         ident_mem[wr_idx] <= wr_id;
         per_mem[wr_idx]   <= wr_per;
      end
      if (dl_we) begin
         dl_mem[wr_idx] <= wr_dl;
      end
      rd_slot_ff <= rd_idx;
      rd_id_ff   <= ident_mem[rd_idx];
      rd_dl_ff   <= dl_mem[rd_idx];
      rd_per_ff  <= per_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         res_buf_ff[buf_idx] <= buf_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_expired   = rsp_exp_ff;
   assign rsp_any_armed = rsp_any_ff;
   assign rsp_time_left = rsp_left_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: hdl/tqe_check.sv
// Port-level checks of the timer queue engine, bound to the top level.
`include "assert_macros.svh"

module tqe_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_id,
   input logic        rsp_expired,
   input logic        rsp_any_armed,
   input logic [31:0] rsp_time_left
);

   `TQE_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_status <= tqe_pkg::STS_NOT_FOUND)
   `TQE_ASSERT(a_expired_ok, clock, reset, rsp_valid && rsp_expired |-> rsp_status == tqe_pkg::STS_OK)
   `TQE_ASSERT(a_idle_left, clock, reset, rsp_valid && !rsp_any_armed |-> rsp_time_left == '0)
   `TQE_ASSERT(a_fail_noid, clock, reset, rsp_valid && rsp_status != tqe_pkg::STS_OK |-> rsp_result_id == '0)
   `TQE_HOLD(a_hold_id, clock, reset, rsp_valid && rsp_stall, rsp_result_id)

endmodule

bind timer_queue_engine_top tqe_check u_tqe_check (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_result_id (rsp_result_id),
   .rsp_expired   (rsp_expired),
   .rsp_any_armed (rsp_any_armed),
   .rsp_time_left (rsp_time_left)
);
